FILE: rtl/lfga_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfga_pkg
// Shared types and constants of the lowest-free gate allocator.
// ----------------------------------------------------------------------------
package lfga_pkg;

  localparam int MAX_GATES_DEF = 64;
  localparam int GATES_RESET   = 64;

  localparam int CFG_W   = 7;
  localparam int TIME_W  = 32;
  localparam int COUNT_W = 32;
  localparam int GNUM_W  = 7;
  localparam int LIMIT_W = 7;

  localparam int IN_DATA_W  = 72;  // 71 bits of fields, padded to 9 bytes
  localparam int OUT_DATA_W = 40;  // 40 bits of fields, exactly 5 bytes

  localparam logic [COUNT_W-1:0] SAT_COUNT = '1;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  // One input item.
  typedef struct packed {
    logic               mode;
    logic [TIME_W-1:0]  arrival_time;
    logic [TIME_W-1:0]  departure_time;
    logic [LIMIT_W-1:0] prefix_limit;
  } item_t;

  // One result item.
  typedef struct packed {
    logic               granted;
    logic [GNUM_W-1:0]  gate_number;
    logic [COUNT_W-1:0] prefix_served;
  } result_t;

  // One entry of the gate table.
  typedef struct packed {
    logic               busy;
    logic [TIME_W-1:0]  held_until;
    logic [COUNT_W-1:0] grant_count;
  } entry_t;

endpackage : lfga_pkg
`default_nettype wire

FILE: rtl/lfga_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfga_table
// Gate table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lfga_table
  import lfga_pkg::*;
#(
  parameter int MAX_GATES = MAX_GATES_DEF,
  parameter int IDX_W     = (MAX_GATES > 1) ? $clog2(MAX_GATES) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [IDX_W-1:0] waddr_i,
  input  wire entry_t           wdata_i,
  input  wire logic             re_i,
  input  wire logic [IDX_W-1:0] raddr_i,
  output entry_t                rdata_o
);

  entry_t mem_q [MAX_GATES];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule : lfga_table
`default_nettype wire

FILE: rtl/lfga_scan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfga_scan
// Sequencer that sweeps the gate table once per item, releasing, granting
// and summing in a read-modify-write pass.
// ----------------------------------------------------------------------------
module lfga_scan
  import lfga_pkg::*;
#(
  parameter int MAX_GATES = MAX_GATES_DEF,
  parameter int IDX_W     = (MAX_GATES > 1) ? $clog2(MAX_GATES) : 1,
  parameter int CNT_W     = $clog2(MAX_GATES + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire item_t            item_i,
  input  wire logic [CFG_W-1:0] gates_in_use_i,
  output logic                  ready_o,
  output logic                  res_valid_o,
  output result_t               res_o,
  input  wire logic             res_ready_i,
  output logic                  mem_we_o,
  output logic [IDX_W-1:0]      mem_waddr_o,
  output entry_t                mem_wdata_o,
  output logic                  mem_re_o,
  output logic [IDX_W-1:0]      mem_raddr_o,
  input  wire entry_t           mem_rdata_i
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(MAX_GATES - 1);
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_GATES);

  logic [1:0]         state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               rvld_q, rvld_d;
  logic [CNT_W-1:0]   ridx_q, ridx_d;

  logic               mode_q;
  logic [TIME_W-1:0]  arrival_q;
  logic [TIME_W-1:0]  departure_q;
  logic [CNT_W-1:0]   limit_q;
  logic [CNT_W-1:0]   usable_q;

  logic               granted_q, granted_d;
  logic [GNUM_W-1:0]  gate_q, gate_d;
  logic [COUNT_W-1:0] sum_q, sum_d;

  logic [31:0]        gates32;
  logic [31:0]        limit32;
  logic [CNT_W-1:0]   usable_in;
  logic [CNT_W-1:0]   limit_in;

  logic               released;
  logic               busy_now;
  logic [COUNT_W:0]   sum_wide;
  logic [COUNT_W-1:0] count_inc;
  logic [CNT_W:0]     gate_num_wide;

  // Clamp the register and the prefix limit to the table depth.
  assign gates32   = 32'(gates_in_use_i);
  assign limit32   = 32'(item_i.prefix_limit);
  assign usable_in = (gates32 > 32'(MAX_GATES)) ? CNT_MAX : CNT_W'(gates32);
  assign limit_in  = (limit32 > 32'(MAX_GATES)) ? CNT_MAX : CNT_W'(limit32);

  assign released      = mem_rdata_i.busy && (mem_rdata_i.held_until < arrival_q);
  assign busy_now      = mem_rdata_i.busy && !released;
  assign sum_wide      = {1'b0, sum_q} + {1'b0, mem_rdata_i.grant_count};
  assign count_inc     = (mem_rdata_i.grant_count == SAT_COUNT) ? SAT_COUNT :
                         mem_rdata_i.grant_count + COUNT_W'(1);
  assign gate_num_wide = {1'b0, ridx_q} + (CNT_W + 1)'(1);

  assign ready_o     = (state_q == ST_IDLE) || ((state_q == ST_DONE) && res_ready_i);
  assign res_valid_o = (state_q == ST_DONE);
  assign res_o       = '{granted: granted_q, gate_number: gate_q, prefix_served: sum_q};

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    rvld_d      = 1'b0;
    ridx_d      = cnt_q;
    granted_d   = granted_q;
    gate_d      = gate_q;
    sum_d       = sum_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = ridx_q[IDX_W-1:0];
    mem_wdata_o = mem_rdata_i;
    mem_re_o    = 1'b0;
    mem_raddr_o = cnt_q[IDX_W-1:0];

    case (state_q)
      ST_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = cnt_q[IDX_W-1:0];
        mem_wdata_o = '0;
        cnt_d       = cnt_q + CNT_W'(1);
        if (cnt_q == LAST_IDX) begin
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (cnt_q != CNT_MAX) begin
          mem_re_o = 1'b1;
          rvld_d   = 1'b1;
          cnt_d    = cnt_q + CNT_W'(1);
        end
        if (rvld_q) begin
          if (mode_q == MODE_READ) begin
            if (ridx_q < limit_q) begin
              sum_d = sum_wide[COUNT_W] ? SAT_COUNT : sum_wide[COUNT_W-1:0];
            end
          end else if (!granted_q && (ridx_q < usable_q) && !busy_now) begin
            mem_we_o    = 1'b1;
            mem_wdata_o = '{busy: 1'b1, held_until: departure_q, grant_count: count_inc};
            granted_d   = 1'b1;
            gate_d      = GNUM_W'(gate_num_wide);
          end else if (released) begin
            mem_we_o         = 1'b1;
            mem_wdata_o.busy = 1'b0;
          end
          if (ridx_q == LAST_IDX) begin
            state_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // A new item may start from idle or in the cycle its predecessor leaves.
    if (start_i) begin
      state_d   = ST_SCAN;
      cnt_d     = '0;
      rvld_d    = 1'b0;
      granted_d = 1'b0;
      gate_d    = '0;
      sum_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      cnt_q   <= '0;
      rvld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rvld_q  <= rvld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ridx_q    <= ridx_d;
    granted_q <= granted_d;
    gate_q    <= gate_d;
    sum_q     <= sum_d;
    if (start_i) begin
      mode_q      <= item_i.mode;
      arrival_q   <= item_i.arrival_time;
      departure_q <= item_i.departure_time;
      limit_q     <= limit_in;
      usable_q    <= usable_in;
    end
  end

  a_grant_has_gate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.granted |-> res_o.gate_number != '0)
    else $error("grant reported without a gate number");

  a_read_no_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (mode_q == MODE_READ) |-> !res_o.granted && (res_o.gate_number == '0))
    else $error("read transaction reported a grant");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) || (state_q == ST_DONE) |-> !mem_we_o)
    else $error("table written outside a sweep");

  a_write_follows_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) && mem_we_o |-> $past(mem_re_o) && (mem_waddr_o == $past(mem_raddr_o)))
    else $error("table write does not match the entry read before");

endmodule : lfga_scan
`default_nettype wire

FILE: rtl/lowest_free_gate_allocator_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lowest_free_gate_allocator_core
// Each input transaction sweeps the whole gate table; its result is then
// loaded into the output register. A new input transaction is taken only
// once the sweep before it has ended and its result has been handed over.
// Reset: gates_in_use returns to 64 and a clearing pass zeroes the table;
// no input transaction is taken until it ends.
// ----------------------------------------------------------------------------
module lowest_free_gate_allocator_core
  import lfga_pkg::*;
#(
  parameter int MAX_GATES = MAX_GATES_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Configuration write channel: gates_in_use.
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_W-1:0]      cfg_data_i,
  // Input stream.
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // tdata: arrival_time[31:0], departure_time[63:32], prefix_limit[70:64],
  // zero padding[71]
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: mode (0 = allocation request, 1 = read of grant counts)
  input  wire logic                  s_axis_tuser,
  // Result stream.
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // tdata: granted[0], gate_number[7:1], prefix_served[39:8]
  output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

  localparam int IDX_W = (MAX_GATES > 1) ? $clog2(MAX_GATES) : 1;
  localparam int CNT_W = $clog2(MAX_GATES + 1);

  // The one configuration register. Writes are always taken; software must
  // only change it while the block has no transaction in flight; the block does not enforce this.
  logic [CFG_W-1:0] gates_in_use_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gates_in_use_q <= CFG_W'(GATES_RESET);
    end else if (cfg_valid_i) begin
      gates_in_use_q <= cfg_data_i;
    end
  end

  // Unpack the input transaction.
  item_t item;

  assign item.mode           = s_axis_tuser;
  assign item.arrival_time   = s_axis_tdata[31:0];
  assign item.departure_time = s_axis_tdata[63:32];
  assign item.prefix_limit   = s_axis_tdata[70:64];

  logic    scan_ready;
  logic    start;
  logic    res_valid;
  result_t res;
  logic    res_ready;

  assign s_axis_tready = scan_ready;
  assign start         = s_axis_tvalid && scan_ready;

  // Gate table traffic between the sequencer and the memory.
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;
  entry_t           mem_rdata;

  lfga_table #(
    .MAX_GATES (MAX_GATES),
    .IDX_W     (IDX_W)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Each item sweeps every entry: allocation requests release expired gates
  // and claim the lowest free one in the usable range, reads accumulate the
  // grant counts below the prefix limit with saturation.
  lfga_scan #(
    .MAX_GATES (MAX_GATES),
    .IDX_W     (IDX_W),
    .CNT_W     (CNT_W)
  ) u_scan (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .item_i         (item),
    .gates_in_use_i (gates_in_use_q),
    .ready_o        (scan_ready),
    .res_valid_o    (res_valid),
    .res_o          (res),
    .res_ready_i    (res_ready),
    .mem_we_o       (mem_we),
    .mem_waddr_o    (mem_waddr),
    .mem_wdata_o    (mem_wdata),
    .mem_re_o       (mem_re),
    .mem_raddr_o    (mem_raddr),
    .mem_rdata_i    (mem_rdata)
  );

  // Output register. It frees the sequencer as soon as a result is handed
  // over, so the next input transaction can be taken while a finished result
  // still waits for the downstream side.
  logic                  out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;

  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_data_q <= {res.prefix_served, res.gate_number, res.granted};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule : lowest_free_gate_allocator_core
`default_nettype wire

FILE: sim/lowest_free_gate_allocator_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lowest_free_gate_allocator_core_tb
// Self-checking bench for the gate allocator. A scoreboard class keeps its
// own gate table, works out the expected grant or read sum for each
// accepted input transaction, and compares every output transaction with
// the oldest expectation. A directed opening is followed by random phases,
// each run under its own gates_in_use setting, with random stalls on both
// streams except in phase 4.
// ----------------------------------------------------------------------------
module lowest_free_gate_allocator_core_tb;
  import lfga_pkg::*;

  localparam int GATES      = MAX_GATES_DEF;
  // Settle for longer than one sweep of the gate table.
  localparam int SETTLE     = GATES + 16;
  localparam int IDLE_PCT   = 17;
  localparam int REPORT_MAX = 10;
  localparam int PHASES     = 10;

  // --------------------------------------------------------------------------
  // Scoreboard: a shadow of the gate table plus the queue of results that
  // the block still owes us.
  // --------------------------------------------------------------------------
  class gate_grant_scoreboard;
    bit                 occupied[GATES];
    logic [TIME_W-1:0]  release_time[GATES];
    logic [COUNT_W-1:0] grant_tally[GATES];
    logic [CFG_W-1:0]   gates_setting;
    result_t            owed_results[$];
    int unsigned        fails;

    function new();
      for (int i = 0; i < GATES; i++) begin
        occupied[i]     = 1'b0;
        release_time[i] = '0;
        grant_tally[i]  = '0;
      end
      gates_setting = CFG_W'(GATES_RESET);
      fails = 0;
    endfunction

    function void set_gates(logic [CFG_W-1:0] value);
      gates_setting = value;
    endfunction

    // Called once per accepted input transaction.
    function void note_accepted(item_t it);
      result_t         want;
      int unsigned     limit;
      int unsigned     usable;
      longint unsigned sum;
      bit              found;
      want   = '0;
      found  = 1'b0;
      sum    = 0;
      limit  = (it.prefix_limit > GATES) ? GATES : it.prefix_limit;
      usable = (gates_setting > GATES) ? GATES : gates_setting;
      if (it.mode == MODE_READ) begin
        for (int i = 0; i < limit; i++) begin
          sum += grant_tally[i];
          if (sum > 64'(SAT_COUNT)) sum = 64'(SAT_COUNT);
        end
        want.prefix_served = sum[COUNT_W-1:0];
      end else begin
        // Release pass covers the whole table, not only the usable gates.
        for (int i = 0; i < GATES; i++) begin
          if (occupied[i] && release_time[i] < it.arrival_time) occupied[i] = 1'b0;
        end
        for (int i = 0; i < usable; i++) begin
          if (!found && !occupied[i]) begin
            found           = 1'b1;
            occupied[i]     = 1'b1;
            release_time[i] = it.departure_time;
            if (grant_tally[i] != SAT_COUNT) grant_tally[i] = grant_tally[i] + 1'b1;
            want.granted     = 1'b1;
            want.gate_number = GNUM_W'(i + 1);
          end
        end
      end
      owed_results.push_back(want);
    endfunction

    // Called once per accepted output transaction.
    function void check_result(logic [OUT_DATA_W-1:0] word);
      result_t got;
      result_t want;
      got.granted       = word[0];
      got.gate_number   = word[7:1];
      got.prefix_served = word[39:8];
      if (owed_results.size() == 0) begin
        fails++;
        if (fails <= REPORT_MAX)
          $display("%0t: result with nothing expected: granted=%0b gate=%0d sum=%0d",
                   $realtime, got.granted, got.gate_number, got.prefix_served);
        return;
      end
      want = owed_results.pop_front();
      if (got.granted !== want.granted || got.gate_number !== want.gate_number ||
          got.prefix_served !== want.prefix_served) begin
        fails++;
        if (fails <= REPORT_MAX)
          $display("%0t: mismatch: granted %0b/%0b gate %0d/%0d sum %0d/%0d (exp/act)",
                   $realtime, want.granted, got.granted, want.gate_number,
                   got.gate_number, want.prefix_served, got.prefix_served);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block ports. Every input starts at a known value.
  // --------------------------------------------------------------------------
  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_W-1:0]      cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  s_axis_tuser  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  // When set, neither side inserts idle cycles.
  bit                    no_gaps = 1'b0;

  gate_grant_scoreboard  sb = new();

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  lowest_free_gate_allocator_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // --------------------------------------------------------------------------
  // Result side. The ready line stalls at random; the check runs in the
  // active region of the edge, so it sees the values from before the edge,
  // which are the ones the handshake used.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    m_axis_tready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  // --------------------------------------------------------------------------
  // Input side.
  // --------------------------------------------------------------------------
  function automatic item_t make_alloc(logic [TIME_W-1:0] arrive, logic [TIME_W-1:0] depart);
    item_t it;
    it                = '0;
    it.mode           = MODE_ALLOC;
    it.arrival_time   = arrive;
    it.departure_time = depart;
    return it;
  endfunction

  function automatic item_t make_read(logic [LIMIT_W-1:0] limit);
    item_t it;
    it              = '0;
    it.mode         = MODE_READ;
    it.prefix_limit = limit;
    return it;
  endfunction

  // Offers one item, with optional idle cycles first, and returns at the
  // edge where the transaction is taken. The valid line is left high so
  // back-to-back items see no bubble.
  task automatic send_item(item_t it);
    while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.mode;
    s_axis_tdata  <= {1'b0, it.prefix_limit, it.departure_time, it.arrival_time};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_accepted(it);
  endtask

  // Stops offering items and waits for every owed result. At least one
  // edge always passes, so the next drive lands in a later time step.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.owed_results.size() != 0);
  endtask

  // The register is only written with the block idle.
  task automatic write_gates(logic [CFG_W-1:0] value);
    drain_results();
    repeat (SETTLE) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_gates(value);
    cfg_valid_i <= 1'b0;
  endtask

  // One random phase. Most items are allocation requests along a slowly
  // advancing time line, so gates fill and free in a realistic way; the
  // rest are reads and requests with arbitrary times.
  task automatic run_phase(int gates, int span, int count, bit drain_midway);
    item_t             it;
    logic [TIME_W-1:0] now;
    int unsigned       pick;
    write_gates(CFG_W'(gates));
    now = ($urandom_range(1)) ? $urandom() : TIME_W'($urandom_range(1000));
    for (int k = 0; k < count; k++) begin
      if (drain_midway && k == count / 2) drain_results();
      pick = $urandom_range(99);
      now  = now + $urandom_range(3);
      if (pick < 75) begin
        it = make_alloc(now, now + $urandom_range(span));
      end else if (pick < 85) begin
        it = make_read(LIMIT_W'($urandom_range(127)));
      end else if (pick < 95) begin
        it = make_alloc($urandom(), $urandom());
      end else begin
        it = make_alloc(now, $urandom());
      end
      send_item(it);
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus and the final verdict.
  // --------------------------------------------------------------------------
  initial begin
    int plan_gates[PHASES] = '{64, 0, 1, 127, 2, 65, 64, -1, 3, 64};
    int plan_span[PHASES]  = '{40, 20, 5, 100000, 10, 3000, 8, -1, 50, 200};
    int plan_count[PHASES] = '{60, 40, 50, 110, 60, 60, 60, 60, 50, 50};

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed opening at the reset setting of 64 gates. The early grants
    // exercise the strict compare: a gate held until time 0 stays busy for
    // a request arriving at 0 and frees for one arriving at 1.
    send_item(make_read(7'd64));
    send_item(make_alloc(32'd0, 32'd0));
    send_item(make_alloc(32'd0, 32'd5));
    send_item(make_alloc(32'd1, 32'hFFFF_FFFF));
    send_item(make_read(7'd0));
    send_item(make_read(7'd127));
    send_item(make_read(7'd1));
    send_item(make_alloc(32'd6, 32'd10));
    send_item(make_alloc(32'hFFFF_FFFF, 32'hFFFF_FFFF));
    // Arrival earlier than the one before it: taken as given.
    send_item(make_alloc(32'd5, 32'd7));
    send_item(make_read(7'd65));

    // No gates in use: refused, but the release of gate 3 still happens.
    write_gates(CFG_W'(0));
    send_item(make_alloc(32'd8, 32'd9));
    send_item(make_read(7'd64));

    // A setting above the table size acts as the full table.
    write_gates(CFG_W'(127));
    send_item(make_alloc(32'd8, 32'd20));

    // One gate in use while gate 3 is busy above it; it still frees.
    write_gates(CFG_W'(1));
    send_item(make_alloc(32'd8, 32'd8));
    send_item(make_alloc(32'd21, 32'd30));
    send_item(make_read(7'd3));

    // Random phases. Phase 4 runs with no idling on either side, phase 6
    // holds the sender until the block has caught up halfway through, and
    // phase 7 takes a random setting and time spread.
    for (int p = 0; p < PHASES; p++) begin
      no_gaps = (p == 4);
      run_phase((plan_gates[p] < 0) ? $urandom_range(127) : plan_gates[p],
                (plan_span[p] < 0) ? $urandom_range(5000) : plan_span[p],
                plan_count[p], p == 6);
    end
    no_gaps = 1'b0;

    drain_results();
    repeat (SETTLE) @(posedge clk_i);
    if (sb.fails == 0 && sb.owed_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
